>>> sv/grs_pkg.sv
// Shared types and constants for the graph reachability search block.
package grs_pkg;

  localparam int MAX_NODES_DEF = 256;

  // Width of one adjacency slice examined per scan cycle.
  localparam int CHUNK   = 16;
  localparam int CHUNK_W = $clog2(CHUNK);

  localparam int NODE_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_ADD    = 2'd1;
  localparam logic [1:0] FN_SEARCH = 2'd2;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_SELF  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_POP,
    S_POP_W,
    S_SCAN,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic               hit;
    logic [CHUNK_W-1:0] off;
  } pick_t;

endpackage

>>> sv/grs_chunk_pick.sv
// Lowest-set-bit picker over one adjacency slice of unvisited neighbors.
module grs_chunk_pick (
  input  logic [grs_pkg::CHUNK-1:0] cand,
  output grs_pkg::pick_t            pick
);

  always_comb begin
    pick.hit = 1'b0;
    pick.off = '0;
    for (int j = grs_pkg::CHUNK - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick.hit = 1'b1;
        pick.off = grs_pkg::CHUNK_W'(j);
      end
    end
  end

endmodule

>>> sv/graph_reachability_search.sv
// Top level: adjacency matrix memory, walk stack memory and the search sequencer.
//
// Undirected graph of up to MAX_NODES nodes held as an adjacency bit matrix in a
// single-port-read, single-port-write RAM (one row per node), with the depth-first
// walk stack in a second RAM. After reset a clearing pass writes one row a cycle,
// during which no item is taken; a clear item runs the same pass and replies when
// it ends. An add-edge item reads and writes both rows when the edge is new, only
// reads one row when it is a duplicate, and is rejected up front when out of range
// or a self loop. A search pops each reached node and fetches its row, then scans
// the row 16 bits at a time, pushing each unvisited neighbor as it is found, and
// replies once the stack is empty. Results wait in an output register.
module graph_reachability_search #(
  parameter int MAX_NODES = grs_pkg::MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: node_a [7:0], node_b [15:8]
  input  logic [15:0] in_tdata,
  // tuser: func [1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: reachable_flag [0], reached_count [9:1], zero fill [15:10]
  output logic [15:0] out_tdata,
  // tuser: status [2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int KW   = (CW > grs_pkg::COUNT_W) ? CW : grs_pkg::COUNT_W;
  localparam int NCH  = (MAX_NODES + grs_pkg::CHUNK - 1) / grs_pkg::CHUNK;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PADW = NCH * grs_pkg::CHUNK;
  localparam int IW   = CHW + grs_pkg::CHUNK_W;
  localparam int XW   = (IW > KW) ? IW : KW;

  grs_pkg::state_t state_r, state_nxt;

  logic [8:0]           ncount_r;
  logic [NW-1:0]        a_r, a_nxt, b_r, b_nxt;
  logic [NW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                 clr_reply_r, clr_reply_nxt;
  logic [MAX_NODES-1:0] vis_r, vis_nxt;
  logic [CW-1:0]        depth_r, depth_nxt, depth_m1;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CHW-1:0]       chunk_r, chunk_nxt;
  logic [2:0]           res_status_r, res_status_nxt;
  logic                 res_flag_r, res_flag_nxt;
  logic [8:0]           res_count_r, res_count_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [2:0]           out_tuser_r, out_tuser_nxt;
  logic [15:0]          out_tdata_r, out_tdata_nxt;

  // Adjacency RAM
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] adj_rd_r, adj_wdata;
  logic [NW-1:0]        adj_raddr, adj_waddr;
  logic                 adj_re, adj_we;

  // Walk stack RAM
  logic [NW-1:0] stk_mem [MAX_NODES];
  logic [NW-1:0] stk_rd_r, stk_wdata, stk_raddr, stk_waddr;
  logic          stk_re, stk_we;

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rd_r <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  // Effective node count and range checks on the incoming item
  logic [KW-1:0] ncx, n_eff;
  logic [NW-1:0] in_a_idx, in_b_idx;
  logic          in_rng_ok;

  assign ncx       = KW'(ncount_r);
  assign n_eff     = (ncx > KW'(MAX_NODES)) ? KW'(MAX_NODES) : ncx;
  assign in_a_idx  = NW'(in_tdata[7:0]);
  assign in_b_idx  = NW'(in_tdata[15:8]);
  assign in_rng_ok = (KW'(in_tdata[7:0]) < n_eff) && (KW'(in_tdata[15:8]) < n_eff);

  // Scan slice: row bits of unvisited in-range neighbors
  logic [PADW-1:0]              row_pad, vis_pad;
  logic [grs_pkg::CHUNK-1:0]    row_ch, vis_ch, rng_ch, cand;
  grs_pkg::pick_t               pick;
  logic [NW-1:0]                push_idx;

  assign row_pad = PADW'(adj_rd_r);
  assign vis_pad = PADW'(vis_r);
  assign row_ch  = row_pad[chunk_r * grs_pkg::CHUNK +: grs_pkg::CHUNK];
  assign vis_ch  = vis_pad[chunk_r * grs_pkg::CHUNK +: grs_pkg::CHUNK];

  always_comb begin
    for (int j = 0; j < grs_pkg::CHUNK; j++) begin
      rng_ch[j] = XW'({chunk_r, grs_pkg::CHUNK_W'(j)}) < XW'(n_eff);
    end
  end

  assign cand     = row_ch & ~vis_ch & rng_ch;
  assign push_idx = NW'({chunk_r, pick.off});
  assign depth_m1 = depth_r - 1'b1;

  grs_chunk_pick u_pick (
    .cand (cand),
    .pick (pick)
  );

  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    clr_addr_nxt   = clr_addr_r;
    clr_reply_nxt  = clr_reply_r;
    vis_nxt        = vis_r;
    depth_nxt      = depth_r;
    count_nxt      = count_r;
    chunk_nxt      = chunk_r;
    res_status_nxt = res_status_r;
    res_flag_nxt   = res_flag_r;
    res_count_nxt  = res_count_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tuser_nxt  = out_tuser_r;
    out_tdata_nxt  = out_tdata_r;
    adj_re         = 1'b0;
    adj_raddr      = in_a_idx;
    adj_we         = 1'b0;
    adj_waddr      = clr_addr_r;
    adj_wdata      = '0;
    stk_re         = 1'b0;
    stk_raddr      = depth_m1[NW-1:0];
    stk_we         = 1'b0;
    stk_waddr      = depth_r[NW-1:0];
    stk_wdata      = push_idx;
    in_tready      = 1'b0;

    case (state_r)
      grs_pkg::S_CLEAR: begin
        adj_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == NW'(MAX_NODES - 1)) begin
          clr_addr_nxt = '0;
          if (clr_reply_r) begin
            res_status_nxt = grs_pkg::ST_DONE;
            res_flag_nxt   = 1'b0;
            res_count_nxt  = '0;
            state_nxt      = grs_pkg::S_REPLY;
          end else begin
            state_nxt = grs_pkg::S_IDLE;
          end
        end
      end

      grs_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          a_nxt          = in_a_idx;
          b_nxt          = in_b_idx;
          res_flag_nxt   = 1'b0;
          res_count_nxt  = '0;
          res_status_nxt = grs_pkg::ST_DONE;
          state_nxt      = grs_pkg::S_REPLY;
          case (in_tuser)
            grs_pkg::FN_CLEAR: begin
              clr_addr_nxt  = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = grs_pkg::S_CLEAR;
            end
            grs_pkg::FN_ADD: begin
              if (!in_rng_ok) begin
                res_status_nxt = grs_pkg::ST_RANGE;
              end else if (in_tdata[7:0] == in_tdata[15:8]) begin
                res_status_nxt = grs_pkg::ST_SELF;
              end else begin
                adj_re    = 1'b1;
                state_nxt = grs_pkg::S_EDGE_A;
              end
            end
            grs_pkg::FN_SEARCH: begin
              if (!in_rng_ok) begin
                res_status_nxt = grs_pkg::ST_RANGE;
              end else begin
                vis_nxt           = '0;
                vis_nxt[in_a_idx] = 1'b1;
                stk_we            = 1'b1;
                stk_waddr         = '0;
                stk_wdata         = in_a_idx;
                depth_nxt         = CW'(1);
                count_nxt         = CW'(1);
                state_nxt         = grs_pkg::S_POP;
              end
            end
            default: begin
              // unused opcode: plain done reply
            end
          endcase
        end
      end

      grs_pkg::S_EDGE_A: begin
        if (adj_rd_r[b_r]) begin
          res_status_nxt = grs_pkg::ST_DUP;
          state_nxt      = grs_pkg::S_REPLY;
        end else begin
          adj_we          = 1'b1;
          adj_waddr       = a_r;
          adj_wdata       = adj_rd_r;
          adj_wdata[b_r]  = 1'b1;
          adj_re          = 1'b1;
          adj_raddr       = b_r;
          state_nxt       = grs_pkg::S_EDGE_B;
        end
      end

      grs_pkg::S_EDGE_B: begin
        adj_we         = 1'b1;
        adj_waddr      = b_r;
        adj_wdata      = adj_rd_r;
        adj_wdata[a_r] = 1'b1;
        res_status_nxt = grs_pkg::ST_ADDED;
        state_nxt      = grs_pkg::S_REPLY;
      end

      grs_pkg::S_POP: begin
        if (depth_r == '0) begin
          res_status_nxt = grs_pkg::ST_DONE;
          res_flag_nxt   = vis_r[b_r];
          res_count_nxt  = 9'(count_r);
          state_nxt      = grs_pkg::S_REPLY;
        end else begin
          stk_re    = 1'b1;
          depth_nxt = depth_m1;
          state_nxt = grs_pkg::S_POP_W;
        end
      end

      grs_pkg::S_POP_W: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rd_r;
        chunk_nxt = '0;
        state_nxt = grs_pkg::S_SCAN;
      end

      grs_pkg::S_SCAN: begin
        if (pick.hit) begin
          // mark on push, stay on this slice until it runs dry
          vis_nxt[push_idx] = 1'b1;
          stk_we            = 1'b1;
          depth_nxt         = depth_r + 1'b1;
          count_nxt         = count_r + 1'b1;
        end else if (chunk_r == CHW'(NCH - 1)) begin
          state_nxt = grs_pkg::S_POP;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end

      grs_pkg::S_REPLY: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_status_r;
          out_tdata_nxt  = {6'd0, res_count_r, res_flag_r};
          state_nxt      = grs_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = grs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= grs_pkg::S_CLEAR;
      clr_addr_r   <= '0;
      clr_reply_r  <= 1'b0;
      depth_r      <= '0;
      out_tvalid_r <= 1'b0;
      ncount_r     <= 9'd256;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_reply_r  <= clr_reply_nxt;
      depth_r      <= depth_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        ncount_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    vis_r        <= vis_nxt;
    count_r      <= count_nxt;
    chunk_r      <= chunk_nxt;
    res_status_r <= res_status_nxt;
    res_flag_r   <= res_flag_nxt;
    res_count_r  <= res_count_nxt;
    out_tuser_r  <= out_tuser_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> sv/grs_checker.sv
// Port-level assertions for the graph reachability search block, with its bind.
module grs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        cfg_we,
  input logic [8:0]  cfg_wdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= grs_pkg::ST_DONE)
    else $error("status code out of range");

  // only a done-status result, as from a completed search, may carry a flag or a count
  a_edge_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != grs_pkg::ST_DONE) |-> out_tdata == 16'd0)
    else $error("non-search result with search payload");

  a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[9:1] != 9'd0) && (out_tdata[15:10] == 6'd0))
    else $error("reachable with no reached nodes");

endmodule

bind graph_reachability_search grs_checker u_grs_checker (.*);
